// ----- rtl/core/bra_pkg.sv -----
`timescale 1ns / 1ps

package bra_pkg;

	// Fixed field widths of the ports
	localparam int IN_W  = 32;
	localparam int NUM_W = 32;
	localparam int CFG_W = 16;

	// Quotient bits per continued-fraction term, one per cycle
	localparam int DIV_STEPS = 32;
	localparam int STEP_CW   = $clog2(DIV_STEPS);

	// Largest positive numerator
	localparam logic [NUM_W-1:0] NUM_POS_MAX = 32'h7FFF_FFFF;

	// Sequencer commands shared by the divider and the convergent unit
	typedef struct packed {
		logic init;    // load a new item
		logic step;    // one quotient bit
		logic commit;  // close the current term
	} bra_ctl_t;

	// Divider status toward the sequencer and the convergent unit
	typedef struct packed {
		logic qbit;      // quotient bit of this step
		logic rem_zero;  // remainder of the finished term is zero
	} bra_div_t;

endpackage

// ----- rtl/core/best_rational_approximation.sv -----
// Best rational approximation: each input beat carries a signed fixed-point
// value (FRAC_BITS fraction bits) and yields one output beat with the
// continued-fraction convergent of largest denominator not above
// max_denominator, as a signed numerator and an unsigned denominator.
// The expansion runs on the magnitude with exact Euclid steps; the sign goes
// on the numerator. A zero input gives 0/1, a limit of zero gives 1/0, and the
// numerator saturates to the 32-bit signed range. Each term runs through
// the bit-serial restoring divider (one quotient bit a cycle, fed straight
// into the convergent multiply-accumulate) and is then closed in a commit
// step; an item has at most about 24 terms with 16 fraction bits.
// One item is in work at a time; a finished result waits in the output
// register while the next input beat is taken. Write max_denominator
// (reset 65535) only while the block is idle; the write port is always ready.
`timescale 1ns / 1ps

module best_rational_approximation import bra_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int DEN_BITS  = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input beats
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [IN_W-1:0]     value_q,
	// output beats
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [NUM_W-1:0]    numerator,
	output logic        [DEN_BITS-1:0] denominator,
	// limit register write
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic        [CFG_W-1:0]    max_denominator
);

	// Limit width: the register is 16 bits, further masked to DEN_BITS
	localparam int LW = (DEN_BITS < CFG_W) ? DEN_BITS : CFG_W;
	// Numerator width: |h| < |x|*k + 1 with |x| <= 2^(31-FRAC_BITS), k < 2^16
	localparam int HW = 49 - FRAC_BITS;
	// Width for the saturation compare
	localparam int SW = (HW > NUM_W + 1) ? HW : NUM_W + 1;

	localparam logic [SW-1:0] SAT_POS = SW'(NUM_POS_MAX);
	localparam logic [SW-1:0] SAT_NEG = SW'(NUM_POS_MAX) + SW'(1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]         state_q, state_d;
	logic [STEP_CW-1:0] cnt_q;
	logic [LW-1:0]      lim_q;
	logic               neg_q;

	logic               out_valid_q;
	logic [NUM_W-1:0]   numerator_q;
	logic [DEN_BITS-1:0] denominator_q;

	logic               in_take;
	logic               out_load;
	logic               last_step;
	logic [IN_W-1:0]    mag;

	bra_ctl_t           ctl;
	bra_div_t           div_sts;
	logic [HW-1:0]      conv_h;
	logic [LW-1:0]      conv_k;
	logic               conv_stop;

	logic [SW-1:0]      h_ext;
	logic [SW-1:0]      h_sat;
	logic [NUM_W-1:0]   num_nx;

	// ---------------------------------------------------------------
	// Handshakes
	// ---------------------------------------------------------------
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign numerator = numerator_q;
	assign denominator = denominator_q;

	// Result moves to the output register once that register is free
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign last_step = (cnt_q == STEP_CW'(DIV_STEPS - 1));

	// Magnitude of the input; the most negative value maps to 2^31 exactly
	assign mag = value_q[IN_W-1] ? (~value_q + IN_W'(1)) : value_q;

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (last_step) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				// stop on the denominator limit or on an exact remainder
				if (conv_stop || div_sts.rem_zero) state_d = ST_DONE;
				else state_d = ST_RUN;
			end
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RUN) cnt_q <= cnt_q + STEP_CW'(1);
			else cnt_q <= '0;
		end
	end

	always_comb begin
		ctl.init   = in_take;
		ctl.step   = (state_q == ST_RUN);
		ctl.commit = (state_q == ST_COMMIT);
	end

	// Limit register: hold between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			lim_q <= max_denominator[LW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) neg_q <= value_q[IN_W-1];
	end

	// ---------------------------------------------------------------
	// Datapath
	// ---------------------------------------------------------------
	bra_divider #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.ctl     (ctl),
		.dividend(mag),
		.sts     (div_sts)
	);

	bra_conv #(
		.HW(HW),
		.LW(LW)
	) u_conv (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.qbit  (div_sts.qbit),
		.lim   (lim_q),
		.h     (conv_h),
		.k     (conv_k),
		.stop  (conv_stop)
	);

	// Saturate the magnitude, then apply the sign unless the denominator is zero
	always_comb begin
		h_ext = SW'(conv_h);
		if (neg_q && (conv_k != '0)) begin
			h_sat  = (h_ext > SAT_NEG) ? SAT_NEG : h_ext;
			num_nx = ~h_sat[NUM_W-1:0] + NUM_W'(1);
		end else begin
			h_sat  = (h_ext > SAT_POS) ? SAT_POS : h_ext;
			num_nx = h_sat[NUM_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Output register: hold while stalled, drop once taken
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			numerator_q   <= num_nx;
			denominator_q <= DEN_BITS'(conv_k);
		end
	end

endmodule

// ----- rtl/core/bra_divider.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, MSB first.
module bra_divider import bra_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  bra_ctl_t        ctl,
	input  logic [IN_W-1:0] dividend,
	output bra_div_t        sts
);

	localparam int QW = FRAC_BITS + 1;

	logic [IN_W-1:0] dvd_q;
	logic [QW-1:0]   dvs_q;
	logic [QW-1:0]   rem_q;

	logic [QW:0]   trial;
	logic [QW:0]   diff;
	logic          fits;
	logic [QW-1:0] rem_nx;

	always_comb begin
		trial  = {rem_q, dvd_q[IN_W-1]};
		fits   = trial >= {1'b0, dvs_q};
		diff   = trial - {1'b0, dvs_q};
		rem_nx = fits ? diff[QW-1:0] : trial[QW-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			dvd_q <= dividend;
			dvs_q <= QW'(1) << FRAC_BITS;
			rem_q <= '0;
		end else if (ctl.step) begin
			dvd_q <= {dvd_q[IN_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end else if (ctl.commit) begin
			// (p, q) <- (q, r)
			dvd_q <= IN_W'(dvs_q);
			dvs_q <= rem_q;
			rem_q <= '0;
		end
	end

	assign sts.qbit     = fits;
	assign sts.rem_zero = (rem_q == '0);

endmodule

// ----- rtl/core/bra_conv.sv -----
`timescale 1ns / 1ps

// Convergent recurrence h = a*h + hp, k = a*k + kp, fed with the term a
// one bit per cycle, MSB first.
module bra_conv import bra_pkg::*; #(
	parameter int HW = 33,
	parameter int LW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bra_ctl_t      ctl,
	input  logic          qbit,
	input  logic [LW-1:0] lim,
	output logic [HW-1:0] h,
	output logic [LW-1:0] k,
	output logic          stop
);

	logic [HW-1:0] h_q, hp_q, hacc_q;
	logic [LW-1:0] k_q, kp_q, kacc_q;
	logic          over_q;

	logic [HW-1:0] hstep;
	logic [LW+1:0] kstep;
	logic [LW:0]   knew;

	always_comb begin
		hstep = {hacc_q[HW-2:0], 1'b0} + (qbit ? h_q : '0);
		kstep = {1'b0, kacc_q, 1'b0} + (qbit ? (LW+2)'(k_q) : '0);
		knew  = {1'b0, kacc_q} + {1'b0, kp_q};
		stop  = over_q || (knew > {1'b0, lim});
	end

	// Sticky: partial products only grow, so once above the limit, stay there
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_q <= 1'b0;
		end else if (ctl.init || ctl.commit) begin
			over_q <= 1'b0;
		end else if (ctl.step && (kstep > (LW+2)'(lim))) begin
			over_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			h_q    <= HW'(1);
			hp_q   <= '0;
			k_q    <= '0;
			kp_q   <= LW'(1);
			hacc_q <= '0;
			kacc_q <= '0;
		end else if (ctl.step) begin
			hacc_q <= hstep;
			kacc_q <= kstep[LW-1:0];
		end else if (ctl.commit) begin
			if (!stop) begin
				h_q  <= hacc_q + hp_q;
				hp_q <= h_q;
				k_q  <= knew[LW-1:0];
				kp_q <= k_q;
			end
			hacc_q <= '0;
			kacc_q <= '0;
		end
	end

	assign h = h_q;
	assign k = k_q;

endmodule

// ----- rtl/core/bra_checker.sv -----
`timescale 1ns / 1ps

module bra_checker #(
	parameter int DEN_BITS = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic signed [31:0]  numerator,
	input logic [DEN_BITS-1:0] denominator
);

	// A stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// A stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(numerator) && $stable(denominator))
		else $error("output payload changed while stalled");

	// An accepted item keeps the input side busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	// A zero denominator only comes from an empty expansion: 1/0
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (denominator == '0) |-> (numerator == 32'sd1))
		else $error("zero denominator with numerator other than one");

endmodule

bind best_rational_approximation bra_checker #(
	.DEN_BITS(DEN_BITS)
) u_bra_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.numerator  (numerator),
	.denominator(denominator)
);

// ----- dv/tb_best_rational_approximation.sv -----
`timescale 1ns / 1ps

module tb_best_rational_approximation;
	import bra_pkg::*;

	localparam int FRAC_BITS    = 16;
	localparam int DEN_BITS     = 16;
	// Worst case is roughly 800 items, each with its block run, a sender gap and stalls.
	// Take that several times over.
	localparam int CYCLE_LIMIT  = 6_000_000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_PRINTED  = 40;

	// One convergent as it appears on the output beat
	typedef struct packed {
		logic signed [NUM_W-1:0]    num;
		logic        [DEN_BITS-1:0] den;
	} ratio_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [IN_W-1:0]     value_q = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [NUM_W-1:0]    numerator;
	logic        [DEN_BITS-1:0] denominator;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic        [CFG_W-1:0]    max_denominator = '0;

	// Local copy of the limit register; it comes out of reset at its maximum
	logic [CFG_W-1:0] den_limit = 16'hFFFF;

	// Convergents still owed by the block, oldest first
	ratio_t expected_ratios[$];
	ratio_t want;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int stall_run      = 0;
	int cycles         = 0;
	int errors         = 0;
	int items_sent     = 0;
	int results_seen   = 0;
	int limits_written = 0;

	best_rational_approximation #(
		.FRAC_BITS(FRAC_BITS),
		.DEN_BITS (DEN_BITS)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.value_q        (value_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.numerator      (numerator),
		.denominator    (denominator),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.max_denominator(max_denominator)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Expand |raw| / 2^FRAC_BITS with exact Euclid steps and keep the last
	// convergent whose denominator fits under the limit.
	function automatic ratio_t predict_convergent(logic [IN_W-1:0] raw,
			logic [CFG_W-1:0] limit);
		logic [63:0] p, q, h, hp, k, kp, a, r, t, mag;
		logic        neg, done;
		ratio_t      res;
		neg  = raw[IN_W-1];
		// Magnitude in 33 bits so the most negative input stays exact
		p    = neg ? ((64'h1_0000_0000 - {32'd0, raw}) & 64'h1_FFFF_FFFF)
			: {32'd0, raw};
		q    = 64'd1 << FRAC_BITS;
		h    = 64'd1;
		hp   = 64'd0;
		k    = 64'd0;
		kp   = 64'd1;
		done = 1'b0;
		while (q != 0 && !done) begin
			a = p / q;
			if (k * a + kp > {48'd0, limit}) begin
				// next denominator would break the limit: keep what we have
				done = 1'b1;
			end else begin
				t  = h * a + hp;
				hp = h;
				h  = t;
				t  = k * a + kp;
				kp = k;
				k  = t;
				r  = p - a * q;
				if (r == 0) begin
					done = 1'b1;
				end else if (q / r > {32'd0, NUM_POS_MAX}) begin
					// next term too large to carry
					done = 1'b1;
				end else begin
					p = q;
					q = r;
				end
			end
		end
		mag = h;
		// Sign goes on the numerator only when a real convergent exists
		if (k != 0 && neg) begin
			if (mag > 64'h8000_0000)
				mag = 64'h8000_0000;
			res.num = 32'(64'd0 - mag);
		end else begin
			if (mag > {32'd0, NUM_POS_MAX})
				mag = {32'd0, NUM_POS_MAX};
			res.num = mag[NUM_W-1:0];
		end
		res.den = k[DEN_BITS-1:0];
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		if (errors < MAX_PRINTED)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Present one input beat, with an optional gap ahead of it, and hold it
	// until the block takes it. Valid stays high afterward so that the next
	// beat can follow back to back; whoever stops sending drops it.
	task automatic send_value(logic [IN_W-1:0] v);
		int gap;
		gap = 0;
		if (send_idle_pct != 0) begin
			// mostly short gaps, now and then one long enough to land
			// anywhere in the work on the previous item
			if ($urandom_range(15) == 0)
				gap = $urandom_range(900, 1);
			else
				while ($urandom_range(99) < send_idle_pct)
					gap++;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value_q  <= v;
		do @(posedge clk); while (in_stall);
		expected_ratios.push_back(predict_convergent(v, den_limit));
		items_sent++;
	endtask

	// Change the limit only with the block idle: drop valid, wait for every
	// owed beat, then do the write.
	task automatic write_limit(logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (expected_ratios.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid       <= 1'b1;
		max_denominator <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		den_limit = v;
		limits_written++;
	endtask

	function automatic logic [CFG_W-1:0] pick_limit();
		case ($urandom_range(9))
			0:       return '0;
			1:       return 16'd1;
			2:       return 16'hFFFF;
			3:       return 16'($urandom_range(15, 2));
			4, 5:    return 16'($urandom_range(1000, 16));
			default: return 16'($urandom);
		endcase
	endfunction

	// Mix of shapes: plain random, small magnitudes, dyadic fractions that
	// end the expansion early, near-integers, values near full scale, tiny
	function automatic logic [IN_W-1:0] rand_value();
		logic [IN_W-1:0] v;
		int              sh;
		case ($urandom_range(7))
			0, 1, 2: v = $urandom;
			3:       v = $urandom_range(32'h3_FFFF, 0);
			4: begin
				sh = $urandom_range(16, 0);
				v  = $urandom;
				v  = v & ~((32'd1 << sh) - 32'd1);
			end
			5:       v = {16'($urandom), 16'd0} + 32'($urandom_range(16, 0)) - 32'd8;
			6:       v = {1'b0, 15'h7FFF, 16'($urandom)};
			default: v = $urandom_range(255, 0);
		endcase
		if ($urandom_range(1) == 1)
			v = -v;
		return v;
	endfunction

	// Field extremes and well-known constants under the reset limit
	task automatic test_default_limit_extremes();
		send_value(32'h0000_0000);   // zero gives 0/1
		send_value(32'h0000_0001);   // one LSB
		send_value(32'hFFFF_FFFF);   // minus one LSB
		send_value(32'h7FFF_FFFF);   // largest positive
		send_value(32'h8000_0000);   // most negative, magnitude 2^31
		send_value(32'h0001_0000);   // 1.0
		send_value(32'hFFFF_0000);   // -1.0
		send_value(32'h0000_8000);   // 0.5
		send_value(32'h0003_243F);   // pi
		send_value(32'hFFFC_DBC1);   // -pi
		send_value(32'h0001_9E38);   // golden ratio, longest expansion
		send_value(32'h0001_6A0A);   // sqrt 2
		send_value(32'h0000_5555);   // about 1/3
		send_value(32'h7FFF_0000);   // largest integer
	endtask

	// A zero limit admits no term: 1/0 whatever the sign
	task automatic test_zero_limit();
		write_limit('0);
		send_value(32'h0000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'h0003_243F);
		send_value(32'hFFFF_FFFF);
	endtask

	// A limit of one keeps only integer convergents
	task automatic test_unit_limit();
		write_limit(16'd1);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(32'h0001_8000);   // 1.5
		send_value(32'hFFFF_8000);   // -0.5, negative zero numerator
	endtask

	// Random beats under changing limits with one idling mix per call
	task automatic test_random_stream(int count, int s_pct, int r_pct);
		send_idle_pct  = s_pct;
		recv_stall_pct = r_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				write_limit(pick_limit());
			send_value(rand_value());
		end
	endtask

	// Receiver: per-cycle random stalls plus an occasional long hold so
	// that a finished result sits while the next input beat goes in
	always @(posedge clk) begin
		if (stall_run != 0) begin
			out_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else if (recv_stall_pct != 0 && $urandom_range(63) == 0) begin
			out_stall <= 1'b1;
			stall_run <= $urandom_range(300, 1);
		end else begin
			out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Compare each output beat against the oldest owed convergent
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ratios.size() == 0) begin
				report_mismatch($sformatf("result %0d/%0d with nothing owed",
					numerator, denominator));
			end else begin
				want = expected_ratios.pop_front();
				if (numerator !== want.num)
					report_mismatch($sformatf("numerator %0d, want %0d (den %0d)",
						numerator, want.num, want.den));
				if (denominator !== want.den)
					report_mismatch($sformatf("denominator %0d, want %0d (num %0d)",
						denominator, want.den, want.num));
				results_seen++;
			end
		end
	end

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout with %0d results owed", expected_ratios.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_limit_extremes();
		test_zero_limit();
		test_unit_limit();
		test_random_stream(190, 0, 0);
		test_random_stream(190, 73, 0);
		test_random_stream(190, 0, 73);
		test_random_stream(190, 33, 33);
		in_valid <= 1'b0;
		while (expected_ratios.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d of %0d input beats across %0d limit writes,",
			results_seen, items_sent, limits_written);
		$display("with sender gaps and receiver stalls from none up to 73 percent");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/bra_pkg.sv
rtl/core/bra_divider.sv
rtl/core/bra_conv.sv
rtl/core/best_rational_approximation.sv
rtl/core/bra_checker.sv
dv/tb_best_rational_approximation.sv
